@@ hw/rtl/rwl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and sizes for the reader-writer lock manager.
// No dependencies; every other file refers to it by scoped names.
package rwl_pkg;

  localparam int CLIENT_COUNT_DEFAULT = 32;
  localparam int QUEUE_STORE          = 32;
  localparam int ID_W                 = 5;
  localparam int PTR_W                = 5;
  localparam int CNT_W                = 6;
  localparam int LIMIT_W              = 6;
  localparam int HOLD_W               = 7;

  localparam logic signed [HOLD_W-1:0] HOLD_FREE   = 7'sd0;
  localparam logic signed [HOLD_W-1:0] HOLD_WRITER = -7'sd1;
  localparam logic signed [HOLD_W-1:0] HOLD_ONE    = 7'sd1;
  localparam logic signed [HOLD_W-1:0] MAX_READERS = 7'sd63;

  localparam logic [2:0] OP_LOCK            = 3'd0;
  localparam logic [2:0] OP_TRY_LOCK        = 3'd1;
  localparam logic [2:0] OP_UNLOCK          = 3'd2;
  localparam logic [2:0] OP_LOCK_SHARED     = 3'd3;
  localparam logic [2:0] OP_TRY_LOCK_SHARED = 3'd4;
  localparam logic [2:0] OP_UNLOCK_SHARED   = 3'd5;

  localparam logic [2:0] STATUS_GRANTED  = 3'd0;
  localparam logic [2:0] STATUS_QUEUED   = 3'd1;
  localparam logic [2:0] STATUS_REFUSED  = 3'd2;
  localparam logic [2:0] STATUS_RELEASED = 3'd3;
  localparam logic [2:0] STATUS_NOT_HELD = 3'd4;
  localparam logic [2:0] STATUS_FULL     = 3'd5;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_WAKE = 1'b1;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] client;
  } in_item_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] target;
    logic [2:0]      status;
    logic            last;
  } out_item_t;

  typedef enum logic [1:0] {
    WAKE_NONE,
    WAKE_WRITER,
    WAKE_READERS
  } wake_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAKE_WRITER,
    S_WAKE_READERS
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit_writer;
    logic emit_reader;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  slot_free;
    wake_t wake;
    logic  reader_last;
  } dp_status_t;

endpackage

@@ hw/rtl/rwl_fifo.sv @@
`timescale 1ns / 1ps
// Circular queue of waiting client ids with head, tail and fill count.
// Depends on rwl_pkg for sizes.
module rwl_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [rwl_pkg::ID_W-1:0]  push_id,
  input  logic                      pop,
  output logic [rwl_pkg::ID_W-1:0]  head_id,
  output logic [rwl_pkg::CNT_W-1:0] count
);

  logic [rwl_pkg::ID_W-1:0]  slots [rwl_pkg::QUEUE_STORE];
  logic [rwl_pkg::PTR_W-1:0] head;
  logic [rwl_pkg::PTR_W-1:0] tail;

  assign head_id = slots[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/rwl_dp.sv @@
`timescale 1ns / 1ps
// Datapath: holder count, writer and reader queues, grant decision and
// the output register. Depends on rwl_pkg and rwl_fifo.
module rwl_dp #(
  parameter int CLIENT_COUNT = rwl_pkg::CLIENT_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rwl_pkg::in_item_t    in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rwl_pkg::out_item_t   out_data,
  input  rwl_pkg::ctrl_cmd_t   cmd,
  output rwl_pkg::dp_status_t  status
);

  localparam int QUEUE_CAP = (CLIENT_COUNT < rwl_pkg::QUEUE_STORE) ?
                             CLIENT_COUNT : rwl_pkg::QUEUE_STORE;
  localparam logic [rwl_pkg::CNT_W-1:0]   CAP = rwl_pkg::CNT_W'(QUEUE_CAP);
  localparam logic [rwl_pkg::LIMIT_W-1:0] CLIENT_LIMIT =
    rwl_pkg::LIMIT_W'(CLIENT_COUNT);

  logic signed [rwl_pkg::HOLD_W-1:0] holders;
  logic signed [rwl_pkg::HOLD_W-1:0] holders_next;
  logic [rwl_pkg::ID_W-1:0]          wake_id;

  logic [rwl_pkg::ID_W-1:0]  w_head;
  logic [rwl_pkg::ID_W-1:0]  r_head;
  logic [rwl_pkg::CNT_W-1:0] w_count;
  logic [rwl_pkg::CNT_W-1:0] r_count;

  logic                  push_w;
  logic                  push_r;
  logic                  pop_w;
  logic [2:0]            resp_status;
  rwl_pkg::wake_t        wake;

  logic client_bad;
  logic w_empty;
  logic reader_ok;
  logic held_w;
  logic no_readers;

  rwl_fifo u_writers (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.accept && push_w),
    .push_id (in_data.client),
    .pop     (cmd.accept && pop_w),
    .head_id (w_head),
    .count   (w_count)
  );

  rwl_fifo u_readers (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd.accept && push_r),
    .push_id (in_data.client),
    .pop     (cmd.emit_reader),
    .head_id (r_head),
    .count   (r_count)
  );

  assign client_bad = {1'b0, in_data.client} >= CLIENT_LIMIT;
  assign w_empty    = (w_count == '0);
  assign held_w     = (holders == rwl_pkg::HOLD_WRITER);
  assign no_readers = (holders <= rwl_pkg::HOLD_FREE);
  assign reader_ok  = (holders >= rwl_pkg::HOLD_FREE) && w_empty;

  // Grant decision for the request on the input
  always_comb begin
    holders_next = holders;
    push_w       = 1'b0;
    push_r       = 1'b0;
    pop_w        = 1'b0;
    wake         = rwl_pkg::WAKE_NONE;
    resp_status  = rwl_pkg::STATUS_REFUSED;
    if (!client_bad) begin
      unique case (in_data.op)
        rwl_pkg::OP_LOCK, rwl_pkg::OP_TRY_LOCK: begin
          if (holders == rwl_pkg::HOLD_FREE) begin
            holders_next = rwl_pkg::HOLD_WRITER;
            resp_status  = rwl_pkg::STATUS_GRANTED;
          end else if (in_data.op == rwl_pkg::OP_LOCK) begin
            if (w_count >= CAP) begin
              resp_status = rwl_pkg::STATUS_FULL;
            end else begin
              push_w      = 1'b1;
              resp_status = rwl_pkg::STATUS_QUEUED;
            end
          end
        end
        rwl_pkg::OP_UNLOCK: begin
          if (!held_w) begin
            resp_status = rwl_pkg::STATUS_NOT_HELD;
          end else begin
            holders_next = rwl_pkg::HOLD_FREE;
            resp_status  = rwl_pkg::STATUS_RELEASED;
            if (!w_empty) begin
              pop_w = 1'b1;
              wake  = rwl_pkg::WAKE_WRITER;
            end else if (r_count != '0) begin
              wake = rwl_pkg::WAKE_READERS;
            end
          end
        end
        rwl_pkg::OP_LOCK_SHARED, rwl_pkg::OP_TRY_LOCK_SHARED: begin
          if (reader_ok && holders < rwl_pkg::MAX_READERS) begin
            holders_next = holders + rwl_pkg::HOLD_ONE;
            resp_status  = rwl_pkg::STATUS_GRANTED;
          end else if (in_data.op == rwl_pkg::OP_LOCK_SHARED && !reader_ok) begin
            if (r_count >= CAP) begin
              resp_status = rwl_pkg::STATUS_FULL;
            end else begin
              push_r      = 1'b1;
              resp_status = rwl_pkg::STATUS_QUEUED;
            end
          end
        end
        rwl_pkg::OP_UNLOCK_SHARED: begin
          if (no_readers) begin
            resp_status = rwl_pkg::STATUS_NOT_HELD;
          end else begin
            holders_next = holders - rwl_pkg::HOLD_ONE;
            resp_status  = rwl_pkg::STATUS_RELEASED;
            if (holders == rwl_pkg::HOLD_ONE && !w_empty) begin
              pop_w = 1'b1;
              wake  = rwl_pkg::WAKE_WRITER;
            end
          end
        end
        default: begin
          resp_status = rwl_pkg::STATUS_REFUSED;
        end
      endcase
    end
  end

  assign status.slot_free   = !out_valid || out_ready;
  assign status.wake        = wake;
  assign status.reader_last = (r_count == rwl_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      holders <= rwl_pkg::HOLD_FREE;
    end else if (cmd.accept) begin
      holders <= holders_next;
    end
  end

  // Hold the popped writer until its wake notice goes out
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wake_id <= w_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept || cmd.emit_writer || cmd.emit_reader) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.accept) begin
      out_data.kind   <= rwl_pkg::KIND_RESP;
      out_data.target <= in_data.client;
      out_data.status <= resp_status;
      out_data.last   <= (wake == rwl_pkg::WAKE_NONE);
    end else if (cmd.emit_writer) begin
      out_data.kind   <= rwl_pkg::KIND_WAKE;
      out_data.target <= wake_id;
      out_data.status <= rwl_pkg::STATUS_RELEASED;
      out_data.last   <= 1'b1;
    end else if (cmd.emit_reader) begin
      out_data.kind   <= rwl_pkg::KIND_WAKE;
      out_data.target <= r_head;
      out_data.status <= rwl_pkg::STATUS_RELEASED;
      out_data.last   <= status.reader_last;
    end
  end

endmodule

@@ hw/rtl/rwl_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: accepts requests and sequences wake notices into the
// datapath's output register. Depends on rwl_pkg.
module rwl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rwl_pkg::dp_status_t  status,
  output rwl_pkg::ctrl_cmd_t   cmd
);

  rwl_pkg::state_t state;
  rwl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rwl_pkg::S_IDLE: begin
        if (in_valid && status.slot_free) begin
          unique case (status.wake)
            rwl_pkg::WAKE_WRITER:  state_next = rwl_pkg::S_WAKE_WRITER;
            rwl_pkg::WAKE_READERS: state_next = rwl_pkg::S_WAKE_READERS;
            default:               state_next = rwl_pkg::S_IDLE;
          endcase
        end
      end
      rwl_pkg::S_WAKE_WRITER: begin
        if (status.slot_free) begin
          state_next = rwl_pkg::S_IDLE;
        end
      end
      rwl_pkg::S_WAKE_READERS: begin
        if (status.slot_free && status.reader_last) begin
          state_next = rwl_pkg::S_IDLE;
        end
      end
      default: state_next = rwl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.emit_writer = 1'b0;
    cmd.emit_reader = 1'b0;
    unique case (state)
      rwl_pkg::S_IDLE: begin
        in_ready   = status.slot_free;
        cmd.accept = in_valid && status.slot_free;
      end
      rwl_pkg::S_WAKE_WRITER:  cmd.emit_writer = status.slot_free;
      rwl_pkg::S_WAKE_READERS: cmd.emit_reader = status.slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/reader_writer_lock_manager.sv @@
`timescale 1ns / 1ps
// Reader-writer lock manager with writer preference, top level.
// Depends on rwl_pkg, rwl_ctrl, rwl_dp (and rwl_fifo below it).
//
//   channel   direction   handshake               payload
//   in        input       in_valid / in_ready     in_data  (op, client)
//   out       output      out_valid / out_ready   out_data (kind, target, status, last)
//
// The response and every wake notice pass through the single output register;
// no new request is taken until the wake notices of the last one have gone
// out (an unlock wakes the writer at the queue head, or else every queued reader).
// Reset is synchronous; it empties both queues and frees the lock.
// A stalled output holds the register and stops acceptance until it drains.
module reader_writer_lock_manager #(
  parameter int CLIENT_COUNT = rwl_pkg::CLIENT_COUNT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rwl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rwl_pkg::out_item_t out_data
);

  rwl_pkg::ctrl_cmd_t  cmd;
  rwl_pkg::dp_status_t status;

  rwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rwl_dp #(
    .CLIENT_COUNT (CLIENT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

@@ hw/rtl/rwl_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the reader-writer lock manager, bound to the top.
// Depends on rwl_pkg and reader_writer_lock_manager.
module rwl_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rwl_pkg::out_item_t out_data
);

  // Output clears during reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted request is answered by a response in the next cycle
  a_resp_next: assert property (@(posedge clk)
    !rst && in_valid && in_ready |=> out_valid && out_data.kind == rwl_pkg::KIND_RESP)
    else $error("missing response after request");

  // Wake notices always tell the waiter to retry
  a_wake_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == rwl_pkg::KIND_WAKE |->
      out_data.status == rwl_pkg::STATUS_RELEASED)
    else $error("wake notice with wrong status");

  // No new request while the current one still owes results
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("request taken before previous one finished");

endmodule

bind reader_writer_lock_manager rwl_checker u_rwl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ dv/rwl_lock_checker.sv @@
`timescale 1ns / 1ps
// Checker for the reader-writer lock manager: predicts each result from accepted requests
// and compares it with the output channel. Depends on rwl_pkg only.
module rwl_lock_checker #(
  parameter int CLIENT_COUNT = rwl_pkg::CLIENT_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  rwl_pkg::in_item_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  rwl_pkg::out_item_t                  out_data,
  output int                                  fail_count,
  output int                                  results_due,
  output logic signed [rwl_pkg::HOLD_W-1:0]   holders_now,
  output int                                  writers_queued,
  output int                                  readers_queued
);

  localparam int QUEUE_CAP = (CLIENT_COUNT < rwl_pkg::QUEUE_STORE) ?
                             CLIENT_COUNT : rwl_pkg::QUEUE_STORE;

  typedef enum int {
    WRITER_Q = 0,
    READER_Q = 1
  } waiter_q_t;

  logic signed [rwl_pkg::HOLD_W-1:0] lock_holders;
  logic [rwl_pkg::ID_W-1:0]          waiter_ids   [2][rwl_pkg::QUEUE_STORE];
  logic [rwl_pkg::PTR_W-1:0]         waiter_head  [2];
  logic [rwl_pkg::PTR_W-1:0]         waiter_tail  [2];
  int                                waiter_count [2];
  rwl_pkg::out_item_t                expected_results [$];

  task automatic post_result(input logic kind, input logic [rwl_pkg::ID_W-1:0] target,
                             input logic [2:0] status);
    rwl_pkg::out_item_t r;
    r.kind   = kind;
    r.target = target;
    r.status = status;
    r.last   = 1'b0;
    expected_results = {expected_results, r};
  endtask

  task automatic enqueue_waiter(input waiter_q_t q, input logic [rwl_pkg::ID_W-1:0] id);
    if (waiter_count[q] >= QUEUE_CAP) begin
      post_result(rwl_pkg::KIND_RESP, id, rwl_pkg::STATUS_FULL);
    end else begin
      waiter_ids[q][waiter_tail[q]] = id;
      waiter_tail[q] = waiter_tail[q] + 1'b1;
      waiter_count[q]++;
      post_result(rwl_pkg::KIND_RESP, id, rwl_pkg::STATUS_QUEUED);
    end
  endtask

  task automatic wake_head(input waiter_q_t q);
    post_result(rwl_pkg::KIND_WAKE, waiter_ids[q][waiter_head[q]], rwl_pkg::STATUS_RELEASED);
    waiter_head[q] = waiter_head[q] + 1'b1;
    waiter_count[q]--;
  endtask

  task automatic predict_request(input rwl_pkg::in_item_t req);
    logic reader_ok;
    reader_ok = (lock_holders >= rwl_pkg::HOLD_FREE) && (waiter_count[WRITER_Q] == 0);
    if (int'(req.client) >= CLIENT_COUNT) begin
      post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_REFUSED);
    end else begin
      case (req.op)
        rwl_pkg::OP_LOCK, rwl_pkg::OP_TRY_LOCK: begin
          if (lock_holders == rwl_pkg::HOLD_FREE) begin
            lock_holders = rwl_pkg::HOLD_WRITER;
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_GRANTED);
          end else if (req.op == rwl_pkg::OP_TRY_LOCK) begin
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_REFUSED);
          end else begin
            enqueue_waiter(WRITER_Q, req.client);
          end
        end
        rwl_pkg::OP_UNLOCK: begin
          if (lock_holders != rwl_pkg::HOLD_WRITER) begin
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_NOT_HELD);
          end else begin
            lock_holders = rwl_pkg::HOLD_FREE;
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_RELEASED);
            // writers first; otherwise broadcast to every queued reader
            if (waiter_count[WRITER_Q] != 0) begin
              wake_head(WRITER_Q);
            end else begin
              while (waiter_count[READER_Q] != 0) wake_head(READER_Q);
            end
          end
        end
        rwl_pkg::OP_LOCK_SHARED, rwl_pkg::OP_TRY_LOCK_SHARED: begin
          if (reader_ok && lock_holders < rwl_pkg::MAX_READERS) begin
            lock_holders = lock_holders + rwl_pkg::HOLD_ONE;
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_GRANTED);
          end else if (req.op == rwl_pkg::OP_TRY_LOCK_SHARED || reader_ok) begin
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_REFUSED);
          end else begin
            enqueue_waiter(READER_Q, req.client);
          end
        end
        rwl_pkg::OP_UNLOCK_SHARED: begin
          if (lock_holders <= rwl_pkg::HOLD_FREE) begin
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_NOT_HELD);
          end else begin
            lock_holders = lock_holders - rwl_pkg::HOLD_ONE;
            post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_RELEASED);
            if (lock_holders == rwl_pkg::HOLD_FREE && waiter_count[WRITER_Q] != 0) begin
              wake_head(WRITER_Q);
            end
          end
        end
        default: begin
          post_result(rwl_pkg::KIND_RESP, req.client, rwl_pkg::STATUS_REFUSED);
        end
      endcase
    end
    expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic check_result(input rwl_pkg::out_item_t got);
    rwl_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: kind %0d target %0d status %0d last %0d",
             got.kind, got.target, got.status, got.last);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.target !== want.target) begin
        $error("target mismatch: expected %0d, actual %0d", want.target, got.target);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lock_holders = rwl_pkg::HOLD_FREE;
      for (int q = 0; q < 2; q++) begin
        waiter_head[q]  = '0;
        waiter_tail[q]  = '0;
        waiter_count[q] = 0;
      end
      expected_results.delete();
    end else begin
      // compare first: a result leaving now cannot belong to a request entering now
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_request(in_data);
    end
    results_due    = expected_results.size();
    holders_now    = lock_holders;
    writers_queued = waiter_count[WRITER_Q];
    readers_queued = waiter_count[READER_Q];
  end

endmodule

@@ dv/tb_reader_writer_lock_manager.sv @@
`timescale 1ns / 1ps
// Testbench top for the reader-writer lock manager: drives requests, stalls the output,
// and reports the verdict. Depends on rwl_pkg, reader_writer_lock_manager, rwl_lock_checker.
module tb_reader_writer_lock_manager;

  localparam int               REQUEST_TARGET = 350;
  localparam int               IDLE_LIMIT     = 2000;
  localparam int               TAIL_CYCLES    = 50;
  localparam logic [2:0]       OP_UNDEFINED_A = 3'd6;
  localparam logic [2:0]       OP_UNDEFINED_B = 3'd7;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  rwl_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rwl_pkg::out_item_t out_data;

  int                                fail_count;
  int                                results_due;
  logic signed [rwl_pkg::HOLD_W-1:0] holders_now;
  int                                writers_queued;
  int                                readers_queued;

  bit                                calm = 1'b0;
  int                                sent = 0;
  int                                stall_left = 0;
  int                                idle_cycles = 0;
  logic signed [rwl_pkg::HOLD_W-1:0] snap_holders;
  int                                snap_waiters;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reader_writer_lock_manager dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rwl_lock_checker u_lock_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .holders_now    (holders_now),
    .writers_queued (writers_queued),
    .readers_queued (readers_queued)
  );

  // after each result, randomly stall the output unless the bench is calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) stall_left = calm ? 0 : $urandom_range(0, 3);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [rwl_pkg::ID_W-1:0] client);
    int                gap;
    rwl_pkg::in_item_t req;
    gap        = calm ? 0 : $urandom_range(0, 3);
    req.op     = op;
    req.client = client;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [rwl_pkg::ID_W-1:0] any_client();
    return rwl_pkg::ID_W'($urandom_range(0, 31));
  endfunction

  // drop valid, let every expected result drain, and take a snapshot of the lock
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    snap_holders = holders_now;
    snap_waiters = writers_queued + readers_queued;
    @(posedge clk);
  endtask

  // release the lock and empty both queues, one request at a time
  task automatic settle();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      wait_drain();
      if (snap_holders == rwl_pkg::HOLD_WRITER) begin
        send_request(rwl_pkg::OP_UNLOCK, any_client());
      end else if (snap_holders > rwl_pkg::HOLD_FREE) begin
        send_request(rwl_pkg::OP_UNLOCK_SHARED, any_client());
      end else if (snap_waiters != 0) begin
        send_request(rwl_pkg::OP_LOCK, any_client());
      end else begin
        busy = 1'b0;
      end
    end
  endtask

  task automatic mixed_burst();
    int          n;
    int          pick;
    logic [2:0]  op;
    n = $urandom_range(10, 20);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      if (pick < 4) op = rwl_pkg::OP_LOCK;
      else if (pick < 6) op = rwl_pkg::OP_TRY_LOCK;
      else if (pick < 9) op = rwl_pkg::OP_UNLOCK;
      else if (pick < 13) op = rwl_pkg::OP_LOCK_SHARED;
      else if (pick < 15) op = rwl_pkg::OP_TRY_LOCK_SHARED;
      else if (pick < 19) op = rwl_pkg::OP_UNLOCK_SHARED;
      else op = $urandom_range(0, 1) ? OP_UNDEFINED_A : OP_UNDEFINED_B;
      send_request(op, any_client());
    end
  endtask

  // fill the writer queue past capacity, then drain it writer by writer
  task automatic fill_writers();
    settle();
    send_request(rwl_pkg::OP_LOCK, any_client());
    repeat (rwl_pkg::QUEUE_STORE + 1) send_request(rwl_pkg::OP_LOCK, any_client());
    send_request(rwl_pkg::OP_TRY_LOCK, any_client());
    send_request(rwl_pkg::OP_LOCK_SHARED, any_client());
    send_request(rwl_pkg::OP_TRY_LOCK_SHARED, any_client());
    settle();
  endtask

  // queue a full set of readers behind a writer, then wake them all at once
  task automatic broadcast_readers();
    logic [rwl_pkg::ID_W-1:0] owner;
    settle();
    owner = any_client();
    send_request(rwl_pkg::OP_LOCK, owner);
    repeat (rwl_pkg::QUEUE_STORE + 1) send_request(rwl_pkg::OP_LOCK_SHARED, any_client());
    send_request(rwl_pkg::OP_UNLOCK, owner);
    settle();
  endtask

  // push the reader count to its ceiling and one past it
  task automatic saturate_readers();
    settle();
    repeat (int'(rwl_pkg::MAX_READERS) + 1) begin
      send_request(rwl_pkg::OP_LOCK_SHARED, any_client());
    end
    send_request(rwl_pkg::OP_TRY_LOCK_SHARED, any_client());
    send_request(rwl_pkg::OP_LOCK, any_client());
    send_request(rwl_pkg::OP_LOCK_SHARED, any_client());
    send_request(rwl_pkg::OP_TRY_LOCK_SHARED, any_client());
    settle();
  endtask

  initial begin
    int burst;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_request(rwl_pkg::OP_UNLOCK, 5'd0);
    send_request(rwl_pkg::OP_UNLOCK_SHARED, 5'd31);
    send_request(rwl_pkg::OP_TRY_LOCK, 5'd1);
    send_request(rwl_pkg::OP_TRY_LOCK, 5'd2);
    send_request(rwl_pkg::OP_LOCK, 5'd3);
    send_request(rwl_pkg::OP_LOCK_SHARED, 5'd4);
    send_request(rwl_pkg::OP_TRY_LOCK_SHARED, 5'd5);
    send_request(rwl_pkg::OP_UNLOCK, 5'd1);
    send_request(rwl_pkg::OP_LOCK_SHARED, 5'd6);
    send_request(rwl_pkg::OP_TRY_LOCK_SHARED, 5'd7);
    send_request(rwl_pkg::OP_LOCK, 5'd3);
    send_request(rwl_pkg::OP_LOCK_SHARED, 5'd8);
    send_request(rwl_pkg::OP_TRY_LOCK, 5'd9);
    send_request(rwl_pkg::OP_UNLOCK, 5'd0);
    send_request(rwl_pkg::OP_UNLOCK_SHARED, 5'd6);
    send_request(rwl_pkg::OP_UNLOCK_SHARED, 5'd7);
    send_request(rwl_pkg::OP_LOCK, 5'd3);
    send_request(rwl_pkg::OP_UNLOCK_SHARED, 5'd4);
    send_request(rwl_pkg::OP_UNLOCK, 5'd3);
    send_request(OP_UNDEFINED_A, 5'd10);
    send_request(OP_UNDEFINED_B, 5'd31);
    send_request(rwl_pkg::OP_LOCK_SHARED, 5'd31);
    send_request(rwl_pkg::OP_UNLOCK_SHARED, 5'd31);

    burst = 0;
    while (sent < REQUEST_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      case (burst)
        1:       fill_writers();
        3:       broadcast_readers();
        5:       saturate_readers();
        default: mixed_burst();
      endcase
      burst++;
    end
    calm = 1'b0;

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
